FILE: sv/tcsd_pkg.sv
// Package for the two-class softmax detector: sequencer states, request struct
// for the shared multiply unit, and the fixed-point constants.
// No dependencies.
package tcsd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_EXP,
        ST_POLY1,
        ST_POLY2,
        ST_THRESH,
        ST_DONE
    } tcsd_state_t;

    typedef struct packed {
        logic signed [21:0] mul_a;
        logic signed [17:0] mul_b;
        logic signed [15:0] offset;
    } mac_req_t;

    localparam int FRAC_BITS = 15;
    localparam logic signed [17:0] LOG2E_Q15 = 18'sh0B8AA;
    localparam logic signed [15:0] PWR_C0    = 16'sh5A82;
    localparam logic signed [15:0] PWR_C1    = 16'sh1FD7;
    localparam logic signed [17:0] PWR_C2    = 18'sh0057A;
    localparam logic [16:0]        ONE_Q15   = 17'd32768;
    localparam logic [15:0]        RUN_MAX   = 16'hFFFF;
    localparam logic [7:0]         CFG_DETECT_PROBABILITY = 8'd0;
    localparam logic [7:0]         CFG_RUN_LIMIT          = 8'd1;

endpackage

FILE: sv/two_class_softmax_detector_top.sv
// Top level of the two-class softmax detector: sequencer, datapath registers,
// run counter and output register. Depends on tcsd_pkg and tcsd_mac.
//
// Usage:
//   Input channel s_valid/s_ready carries s_score_idle and s_score_event,
//   two signed 32-bit Q15 log-domain scores for one frame.
//   Result channel m_valid/m_ready carries the two Q15 weights, the frame
//   detect flag, the saturating run count and the trigger.
//   Configuration channel cfg_valid/cfg_ready (always ready) writes
//   detect_probability at index 0 and run_limit at index 1; other indexes
//   are ignored. Write only while no frame is in flight.
//   Frames are processed one at a time: the transfer cycle, the score
//   difference, seven products on the single shared multiplier (exponent
//   scale and two polynomial terms for each class, then the threshold
//   product), and the output load; s_ready stays low until the sequencer
//   returns to idle.
//   Reset clears the run counter, loads detect_probability = 16384 and
//   run_limit = 3, and drops m_valid.
//   A stalled receiver holds the result; the sequencer finishes the next
//   frame and waits until the output register frees before loading it.
module two_class_softmax_detector_top
    import tcsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_score_idle,
    input  logic signed [31:0] s_score_event,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_weight_idle,
    output logic [14:0]        m_weight_event,
    output logic               m_frame_detect,
    output logic [15:0]        m_run_count,
    output logic               m_trigger,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    tcsd_state_t state_reg, state_next;
    mac_req_t    req;
    logic signed [24:0] res;
    logic        load;

    logic [14:0] detect_prob_reg;
    logic [14:0] run_limit_reg;
    logic [15:0] run_reg;
    logic [15:0] run_next;

    logic signed [31:0] score_reg [2];
    logic signed [20:0] d_reg [2];
    logic [1:0]         far_reg;
    logic               cls_reg;
    logic signed [16:0] t_reg;
    logic [3:0]         sh_reg;
    logic               zero_reg;
    logic [15:0]        acc1_reg;
    logic [14:0]        w_reg [2];
    logic               det_reg;

    logic               m_valid_reg;
    logic [14:0]        m_weight_idle_reg;
    logic [14:0]        m_weight_event_reg;
    logic               m_frame_detect_reg;
    logic [15:0]        m_run_count_reg;
    logic               m_trigger_reg;

    logic signed [31:0] top;
    logic signed [32:0] diff_idle;
    logic signed [32:0] diff_event;
    logic signed [10:0] ipart;
    logic [10:0]        ineg;
    logic               nz;
    logic signed [16:0] t_calc;
    logic [15:0]        acc_shifted;
    logic [16:0]        thresh;
    logic [15:0]        w_sum;

    tcsd_mac u_mac (
        .req (req),
        .res (res)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign top        = (score_reg[0] > score_reg[1]) ? score_reg[0] : score_reg[1];
    assign diff_idle  = {score_reg[0][31], score_reg[0]} - {top[31], top};
    assign diff_event = {score_reg[1][31], score_reg[1]} - {top[31], top};

    assign nz     = |res[14:0];
    assign ipart  = $signed(res[24:15]) + $signed({10'd0, nz});
    assign ineg   = 11'(-ipart);
    assign t_calc = nz ? ($signed({1'b0, res[14:0], 1'b0}) - $signed(ONE_Q15))
                       : $signed(ONE_Q15);

    assign acc_shifted = res[15:0] >> sh_reg;
    assign thresh      = ONE_Q15 - {2'b00, detect_prob_reg};
    assign w_sum       = {1'b0, w_reg[0]} + {1'b0, w_reg[1]};

    assign run_next = det_reg ? ((run_reg == RUN_MAX) ? run_reg : run_reg + 16'd1) : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        req        = '0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIFF;
            end
            ST_DIFF: begin
                state_next = ST_EXP;
            end
            ST_EXP: begin
                req.mul_a  = {d_reg[cls_reg][20], d_reg[cls_reg]};
                req.mul_b  = LOG2E_Q15;
                state_next = ST_POLY1;
            end
            ST_POLY1: begin
                req.mul_a  = {{5{t_reg[16]}}, t_reg};
                req.mul_b  = PWR_C2;
                req.offset = PWR_C1;
                state_next = ST_POLY2;
            end
            ST_POLY2: begin
                req.mul_a  = {{5{t_reg[16]}}, t_reg};
                req.mul_b  = $signed({2'b00, acc1_reg});
                req.offset = PWR_C0;
                state_next = cls_reg ? ST_THRESH : ST_EXP;
            end
            ST_THRESH: begin
                req.mul_a  = $signed({5'd0, thresh});
                req.mul_b  = $signed({2'b00, w_sum});
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                score_reg[0] <= s_score_idle;
                score_reg[1] <= s_score_event;
                cls_reg      <= 1'b0;
            end
            ST_DIFF: begin
                d_reg[0]   <= diff_idle[20:0];
                d_reg[1]   <= diff_event[20:0];
                far_reg[0] <= ~&diff_idle[32:20] & |diff_idle[32:20];
                far_reg[1] <= ~&diff_event[32:20] & |diff_event[32:20];
            end
            ST_EXP: begin
                t_reg    <= t_calc;
                sh_reg   <= ineg[3:0];
                zero_reg <= far_reg[cls_reg] || (ipart <= -11'sd15);
            end
            ST_POLY1: begin
                acc1_reg <= res[15:0];
            end
            ST_POLY2: begin
                w_reg[cls_reg] <= zero_reg ? 15'd0 : acc_shifted[14:0];
                cls_reg        <= 1'b1;
            end
            ST_THRESH: begin
                det_reg <= ({2'b00, w_reg[0]} <= res[16:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_prob_reg <= 15'd16384;
            run_limit_reg   <= 15'd3;
            run_reg         <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DETECT_PROBABILITY: detect_prob_reg <= cfg_data[14:0];
                    CFG_RUN_LIMIT:          run_limit_reg   <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (load) begin
                run_reg     <= run_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_weight_idle_reg  <= w_reg[0];
            m_weight_event_reg <= w_reg[1];
            m_frame_detect_reg <= det_reg;
            m_run_count_reg    <= run_next;
            m_trigger_reg      <= (run_next >= {1'b0, run_limit_reg});
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_weight_idle  = m_weight_idle_reg;
    assign m_weight_event = m_weight_event_reg;
    assign m_frame_detect = m_frame_detect_reg;
    assign m_run_count    = m_run_count_reg;
    assign m_trigger      = m_trigger_reg;

    a_top_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_weight_idle == 15'd32723 || m_weight_event == 15'd32723))
        else $error("neither class weight is at full scale");

    a_miss_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_detect) |-> (m_run_count == 16'd0))
        else $error("run count not cleared on a miss");

    a_hit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_detect) |-> (m_run_count != 16'd0))
        else $error("run count zero on a detection");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer took a transfer while busy");

endmodule

FILE: sv/tcsd_mac.sv
// Shared multiply unit: offset + floor((a * b) / 2^15), signed.
// Depends on tcsd_pkg for the request struct.
module tcsd_mac
    import tcsd_pkg::*;
(
    input  mac_req_t           req,
    output logic signed [24:0] res
);

    logic signed [39:0] prod;

    assign prod = req.mul_a * req.mul_b;
    assign res  = prod[39:FRAC_BITS] + {{9{req.offset[15]}}, req.offset};

endmodule
